// ----- rtl/psenum_pkg.sv -----
`timescale 1ns / 1ps

package psenum_pkg;

  // character store geometry
  localparam int MaxChars = 512;
  localparam int AddrW    = $clog2(MaxChars);
  localparam int CntW     = AddrW + 1;

  // output field widths
  localparam int StartW = 9;
  localparam int LenW   = 10;

  // action codes
  localparam logic [1:0] ActClear  = 2'd0;
  localparam logic [1:0] ActAppend = 2'd1;
  localparam logic [1:0] ActFetch  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic append;
    logic next_len;
    logic begin_test;
    logic rd;
    logic step;
    logic emit;
    logic hit;
  } ps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic len_ok;
    logic start_ok;
    logic ptr_done;
    logic chars_eq;
    logic out_free;
  } ps_stat_t;

endpackage

// ----- rtl/psenum_ctrl.sv -----
`timescale 1ns / 1ps

module psenum_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           action_i,
  input  psenum_pkg::ps_stat_t stat_i,
  output psenum_pkg::ps_cmd_t  cmd_o,
  output logic                 busy_o
);
  import psenum_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StTest,
    StCmp,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   hit_q, hit_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (action_i)
            ActClear:  cmd_o.clear = 1'b1;
            ActAppend: cmd_o.append = 1'b1;
            ActFetch: begin
              state_d = StScan;
              busy_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (!stat_i.len_ok) begin
          hit_d   = 1'b0;
          state_d = StEmit;
        end else if (!stat_i.start_ok) begin
          cmd_o.next_len = 1'b1;
        end else begin
          cmd_o.begin_test = 1'b1;
          state_d          = StTest;
        end
      end
      StTest: begin
        if (stat_i.ptr_done) begin
          hit_d   = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = StCmp;
        end
      end
      StCmp: begin
        if (stat_i.chars_eq) begin
          cmd_o.step = 1'b1;
          state_d    = StTest;
        end else begin
          state_d = StScan;
        end
      end
      StEmit: begin
        cmd_o.hit = hit_q;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          busy_d     = 1'b0;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      hit_q   <= hit_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- rtl/psenum_dp.sv -----
`timescale 1ns / 1ps

module psenum_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     char_in_i,
  input  psenum_pkg::ps_cmd_t            cmd_i,
  output psenum_pkg::ps_stat_t           stat_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [psenum_pkg::StartW-1:0]  start_pos_o,
  output logic [psenum_pkg::LenW-1:0]    pal_len_o,
  output logic                           overflow_o
);
  import psenum_pkg::*;

  logic [7:0]       mem_q [MaxChars];
  logic [7:0]       rd_a_q, rd_b_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  len_q;
  logic [CntW-1:0]  start_q;
  logic             ovf_q;
  logic [AddrW-1:0] a_q, b_q, s_q;
  logic             out_valid_q;
  logic             found_q;
  logic [StartW-1:0] start_pos_q;
  logic [LenW-1:0]  pal_len_q;
  logic             ovf_out_q;
  logic             room;
  logic [CntW:0]    end_sum;
  logic [CntW-1:0]  last_pos;

  assign room     = count_q < CntW'(MaxChars);
  assign end_sum  = {1'b0, start_q} + {1'b0, len_q};
  assign last_pos = start_q + len_q - CntW'(1);

  // status to controller
  assign stat_o.len_ok   = len_q <= count_q;
  assign stat_o.start_ok = end_sum <= {1'b0, count_q};
  assign stat_o.ptr_done = a_q >= b_q;
  assign stat_o.chars_eq = rd_a_q == rd_b_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // character store write and mirrored read
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && room) begin
      mem_q[count_q[AddrW-1:0]] <= char_in_i;
    end
    if (cmd_i.rd) begin
      rd_a_q <= mem_q[a_q];
      rd_b_q <= mem_q[b_q];
    end
  end

  // fill count, cursor and sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= CntW'(2);
      start_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        len_q   <= CntW'(2);
        start_q <= '0;
      end else if (cmd_i.append) begin
        if (room) begin
          count_q <= count_q + CntW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
        len_q   <= CntW'(2);
        start_q <= '0;
      end else if (cmd_i.next_len) begin
        len_q   <= len_q + CntW'(1);
        start_q <= '0;
      end else if (cmd_i.begin_test) begin
        start_q <= start_q + CntW'(1);
      end
    end
  end

  // compare pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_test) begin
      s_q <= start_q[AddrW-1:0];
      a_q <= start_q[AddrW-1:0];
      b_q <= last_pos[AddrW-1:0];
    end else if (cmd_i.step) begin
      a_q <= a_q + AddrW'(1);
      b_q <= b_q - AddrW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q     <= cmd_i.hit;
      start_pos_q <= cmd_i.hit ? StartW'(s_q) : '0;
      pal_len_q   <= cmd_i.hit ? LenW'(len_q) : '0;
      ovf_out_q   <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign start_pos_o = start_pos_q;
  assign pal_len_o   = pal_len_q;
  assign overflow_o  = ovf_out_q;

endmodule

// ----- rtl/palindrome_substring_enumerator.sv -----
// clear and append words do not stall the input and produce no output word
// a fetch steps through tested starts, compared pairs (both store reads together, then the compare),
// hit closes, length steps and the exhausted check, then loads the output register
// the input stays stalled while the fetch runs and longer while the output word is stalled
// the result sits in an output register, so a new word is taken while it waits
// async active-low reset empties the store, clears overflow and restarts the cursor
`timescale 1ns / 1ps

module palindrome_substring_enumerator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [7:0]                     char_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [psenum_pkg::StartW-1:0]  start_pos_o,
  output logic [psenum_pkg::LenW-1:0]    pal_len_o,
  output logic                           overflow_o
);
  import psenum_pkg::*;

  ps_cmd_t  cmd;
  ps_stat_t stat;

  // sequencer
  psenum_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (in_stall_o)
  );

  // store, cursor and output register
  psenum_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_in_i   (char_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .start_pos_o (start_pos_o),
    .pal_len_o   (pal_len_o),
    .overflow_o  (overflow_o)
  );

endmodule

// ----- rtl/psenum_checker.sv -----
`timescale 1ns / 1ps

module psenum_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [1:0]                     action_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           found_o,
  input logic [psenum_pkg::StartW-1:0]  start_pos_o,
  input logic [psenum_pkg::LenW-1:0]    pal_len_o
);
  import psenum_pkg::*;

  // a held output word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pal_len_o) && $stable(start_pos_o))
    else $error("output word changed while stalled");

  // exhausted answer is all zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> pal_len_o == '0 && start_pos_o == '0)
    else $error("exhausted word carries position or length");

  // reported palindromes are at least two long
  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> pal_len_o >= LenW'(2))
    else $error("reported palindrome shorter than two");

  // a fetch keeps the input stalled while it runs
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ActFetch |=> in_stall_o)
    else $error("input not stalled after fetch");

  // clear and append never stall the input
  a_edit_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ActClear || action_i == ActAppend)
    |=> !in_stall_o)
    else $error("input stalled after clear or append");

endmodule

bind palindrome_substring_enumerator psenum_checker u_psenum_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .start_pos_o (start_pos_o),
  .pal_len_o   (pal_len_o)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import psenum_pkg::*;

  localparam logic [1:0] ActUnused  = 2'd3;
  localparam int         CycleLimit = 8_000_000;
  localparam int         NumWords   = 900;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] ch;
    logic       drain;
  } cmd_word_t;

  typedef struct packed {
    logic              found;
    logic [StartW-1:0] start_pos;
    logic [LenW-1:0]   pal_len;
    logic              overflow;
  } pal_res_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic [1:0]        action     = ActClear;
  logic [7:0]        char_in    = 8'h00;
  logic              out_stall  = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              found;
  logic [StartW-1:0] start_pos;
  logic [LenW-1:0]   pal_len;
  logic              overflow;

  // words still to send and palindrome reports still owed
  cmd_word_t word_q[$];
  pal_res_t  expected_pals[$];

  // predictor copy of the character store and scan cursor
  logic [7:0] txt [MaxChars];
  int         txt_cnt = 0;
  int         scan_len = 2;
  int         scan_start = 0;
  bit         txt_ovf = 1'b0;

  // stimulus side view of the store contents
  logic [7:0] gen_txt [MaxChars];
  int         gen_len = 0;
  int         gen_words = 0;

  int errors = 0;
  int cycles = 0;
  int n_fetch = 0;
  int n_found = 0;
  int n_done = 0;
  int n_ovf_res = 0;
  int n_dropped = 0;
  int longest = 0;

  int        burst_left = 1;
  int        gap_left = 0;
  cmd_word_t nxt;
  pal_res_t  exp_res;
  int        stall_mode = 0;
  int        stall_left = 0;

  palindrome_substring_enumerator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .char_in_i   (char_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .found_o     (found),
    .start_pos_o (start_pos),
    .pal_len_o   (pal_len),
    .overflow_o  (overflow)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // update the store model for one accepted word, queue the report a fetch owes
  task automatic apply_word(input logic [1:0] act, input logic [7:0] ch);
    pal_res_t r;
    bit       hit;
    int       a;
    int       b;
    r = '0;
    hit = 1'b0;
    case (act)
      ActClear: begin
        txt_cnt = 0;
        txt_ovf = 1'b0;
        scan_len = 2;
        scan_start = 0;
      end
      ActAppend: begin
        if (txt_cnt < MaxChars) begin
          txt[txt_cnt] = ch;
          txt_cnt++;
        end else begin
          txt_ovf = 1'b1;
          n_dropped++;
        end
        scan_len = 2;
        scan_start = 0;
      end
      ActFetch: begin
        // resume the length-major scan where the last fetch stopped
        while (!hit && scan_len <= txt_cnt) begin
          if (scan_start + scan_len <= txt_cnt) begin
            a = scan_start;
            b = scan_start + scan_len - 1;
            while (a < b && txt[a] == txt[b]) begin
              a++;
              b--;
            end
            if (a >= b) begin
              hit = 1'b1;
              r.found = 1'b1;
              r.start_pos = StartW'(scan_start);
              r.pal_len = LenW'(scan_len);
              if (scan_len > longest) longest = scan_len;
            end
            scan_start++;
          end else begin
            scan_len++;
            scan_start = 0;
          end
        end
        r.overflow = txt_ovf;
        n_fetch++;
        if (hit) n_found++;
        else n_done++;
        if (txt_ovf) n_ovf_res++;
        expected_pals.push_back(r);
      end
      default: ;
    endcase
  endtask

  // queue one word and track what the store will hold
  task automatic push_word(input logic [1:0] act, input logic [7:0] ch, input bit drain);
    cmd_word_t w;
    w.act = act;
    w.ch = ch;
    w.drain = drain;
    word_q.push_back(w);
    if (act == ActClear) begin
      gen_len = 0;
    end else if (act == ActAppend && gen_len < MaxChars) begin
      gen_txt[gen_len] = ch;
      gen_len++;
    end
    if (act != ActUnused) gen_words++;
  endtask

  // driver: bursts of words with random gaps, optional drain before a word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      action <= ActClear;
      char_in <= 8'h00;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) apply_word(action, char_in);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0 && !(word_q[0].drain && expected_pals.size() > 0)) begin
          nxt = word_q.pop_front();
          in_valid <= 1'b1;
          action <= nxt.act;
          char_in <= nxt.ch;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each report against the oldest expectation, stall on phases
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pals.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected report found=%0d start=%0d len=%0d ovf=%0d",
                     $time, found, start_pos, pal_len, overflow);
        end else begin
          exp_res = expected_pals.pop_front();
          if (found !== exp_res.found || start_pos !== exp_res.start_pos ||
              pal_len !== exp_res.pal_len || overflow !== exp_res.overflow) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp found=%0d start=%0d len=%0d ovf=%0d, got %0d %0d %0d %0d",
                       $time, exp_res.found, exp_res.start_pos, exp_res.pal_len,
                       exp_res.overflow, found, start_pos, pal_len, overflow);
          end
        end
      end
      if (stall_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run limit of %0d cycles reached, %0d reports outstanding",
               CycleLimit, expected_pals.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int         npal;
    int         nf;
    int         k;
    int         a;
    int         b;
    int         mode;
    logic [7:0] base;
    logic [7:0] ch;
    bit         drain;

    // empty store, repeated exhaustion, ignored code, field extremes
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActFetch, 8'hFF, 1'b0);
    push_word(ActUnused, 8'hA5, 1'b0);
    push_word(ActAppend, 8'h00, 1'b0);
    push_word(ActAppend, 8'hFF, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActAppend, 8'hFF, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActAppend, 8'h00, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    // an ignored word must not restart the scan
    push_word(ActUnused, 8'h5A, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActClear, 8'hFF, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    for (int i = 0; i < 3; i++) push_word(ActAppend, 8'h61, 1'b0);
    for (int i = 0; i < 4; i++) push_word(ActFetch, 8'h00, 1'b0);

    // full store: mirrored text with a doubled first character, so centered
    // palindromes up to full length plus a pair at each end (one starts at 510)
    push_word(ActClear, 8'h00, 1'b1);
    for (int i = 0; i < 256; i++) push_word(ActAppend, (i == 0) ? 8'h01 : 8'(i), 1'b0);
    for (int i = 0; i < 256; i++)
      push_word(ActAppend, (i == 255) ? 8'h01 : 8'(255 - i), 1'b0);
    // dropped appends set the sticky flag
    push_word(ActAppend, 8'($urandom_range(0, 255)), 1'b0);
    push_word(ActAppend, 8'($urandom_range(0, 255)), 1'b0);
    for (int i = 0; i < 260; i++) push_word(ActFetch, 8'($urandom_range(0, 255)), 1'b0);
    // a dropped append still restarts the scan
    push_word(ActAppend, 8'h00, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);
    push_word(ActClear, 8'h00, 1'b0);
    push_word(ActFetch, 8'h00, 1'b0);

    while (gen_words < NumWords) begin
      if ($urandom_range(0, 99) < 80) begin
        // well formed: clear or extend, append short text, fetch a run
        drain = ($urandom_range(0, 9) == 0);
        if (gen_len > 40 || $urandom_range(0, 9) < 7)
          push_word(ActClear, 8'($urandom_range(0, 255)), drain);
        else
          push_word(ActAppend, 8'($urandom_range(0, 255)), drain);
        k = $urandom_range(1, 14);
        mode = $urandom_range(0, 9);
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < k; i++) begin
          if (mode == 0) ch = 8'($urandom_range(0, 255));
          else ch = base + 8'($urandom_range(0, (mode < 6) ? 1 : 2));
          push_word(ActAppend, ch, 1'b0);
        end
        npal = 0;
        for (int l = 2; l <= gen_len; l++) begin
          for (int s = 0; s + l <= gen_len; s++) begin
            a = s;
            b = s + l - 1;
            while (a < b && gen_txt[a] == gen_txt[b]) begin
              a++;
              b--;
            end
            if (a >= b) npal++;
          end
        end
        if ($urandom_range(0, 1) == 1) nf = npal + 1 + $urandom_range(0, 2);
        else nf = $urandom_range(0, npal);
        for (int i = 0; i < nf; i++) push_word(ActFetch, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // noise: any code with any character
        push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() > 0 || in_valid || expected_pals.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("%0d fetches checked: %0d palindromes (longest %0d), %0d exhausted answers",
             n_fetch, n_found, longest, n_done);
    $display("%0d reports carried the overflow flag, %0d appends dropped, %0d errors",
             n_ovf_res, n_dropped, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/psenum_pkg.sv
rtl/psenum_ctrl.sv
rtl/psenum_dp.sv
rtl/palindrome_substring_enumerator.sv
rtl/psenum_checker.sv
tb/tb.sv
